/* hw/rtl/tdpt_pkg.sv */
// Package for the trial-division prime test core: default width, controller
// state encoding, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package tdpt_pkg;

	// Default candidate width
	localparam int unsigned VALUE_WIDTH_DEF = 16;

	// Controller states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQR  = 6'b000010,
		ST_CMP  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_CHK  = 6'b010000,
		ST_DONE = 6'b100000
	} tdpt_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // capture candidate, reset divisor to two
		logic sq_en;      // register divisor squared
		logic div_start;  // load divider with candidate
		logic div_step;   // one restoring-division bit
		logic inc_d;      // advance to next divisor
		logic out_load;   // move result into output register
		logic out_prime;  // prime flag that goes with out_load
	} tdpt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic lt2;        // candidate is zero or one
		logic sq_gt;      // divisor squared exceeds candidate
		logic cnt_zero;   // last division bit is being done
		logic rem_zero;   // remainder is zero
		logic out_free;   // output register can take a result
	} tdpt_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tdpt_dp.sv */
// Datapath of the trial-division prime test: candidate and divisor registers,
// squaring multiplier, bit-serial restoring divider and output register.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_dp import tdpt_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tdpt_cmd_t              cmd,
	output tdpt_sts_t                   sts,
	input  wire logic [VALUE_WIDTH-1:0] in_value,
	input  wire logic                   out_ready,
	output logic                        out_valid,
	output logic [VALUE_WIDTH-1:0]      out_value,
	output logic                        out_prime
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned CW = (W > 2) ? $clog2(W) : 1;

	logic [W-1:0]   n_q;
	logic [W-1:0]   d_q;
	logic [2*W-1:0] sq_q;
	logic [W:0]     rem_q;
	logic [W-1:0]   dvd_q;
	logic [CW-1:0]  cnt_q;
	logic           out_valid_q;
	logic [W-1:0]   out_value_q;
	logic           out_prime_q;

	logic [W:0]     shifted;
	logic [W+1:0]   diff;
	logic           ge;

	// Candidate and divisor
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= in_value;
			d_q <= W'(2);
		end else if (cmd.inc_d) begin
			d_q <= d_q + W'(1);
		end
	end

	// Divisor squared, registered
	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			sq_q <= d_q * d_q;
		end
	end

	// Restoring division step: shift in next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q[W-1:0], dvd_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, d_q};
		ge      = ~diff[W+1];
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= n_q;
			cnt_q <= CW'(W-1);
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[W:0] : shifted;
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Output register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= n_q;
			out_prime_q <= cmd.out_prime;
		end
	end

	// Status back to the controller
	always_comb begin
		sts.lt2      = (n_q[W-1:1] == '0);
		sts.sq_gt    = (sq_q > {{W{1'b0}}, n_q});
		sts.cnt_zero = (cnt_q == '0);
		sts.rem_zero = (rem_q == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_prime = out_prime_q;

endmodule

`default_nettype wire

/* hw/rtl/tdpt_ctrl.sv */
// Controller of the trial-division prime test: sequences squaring, division
// and the divisor walk, and decides the prime flag.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_ctrl import tdpt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire tdpt_sts_t sts,
	output tdpt_cmd_t      cmd
);

	tdpt_state_t state_q;
	tdpt_state_t state_d;
	logic        prime_q;
	logic        prime_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		prime_d  = prime_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.sq_en = 1'b1;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				if (sts.lt2) begin
					prime_d = 1'b0;
					state_d = ST_DONE;
				end else if (sts.sq_gt) begin
					prime_d = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.cnt_zero) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.rem_zero) begin
					prime_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					cmd.inc_d = 1'b1;
					state_d   = ST_SQR;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.out_prime = prime_q;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prime_q <= 1'b0;
		end else begin
			state_q <= state_d;
			prime_q <= prime_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/trial_division_prime_test_core.sv */
// Top level of the trial-division prime test: joins controller and datapath.
// Depends on tdpt_pkg, tdpt_ctrl, tdpt_dp.
//
//   channel  | direction | data                         | user
//   s_axis   | in        | candidate                    | -
//   m_axis   | out       | tested_value                 | is_prime
//
// One candidate is in work at a time; the next is taken while a result waits.
// Each divisor tried passes through squaring, compare, the shared restoring
// divider at one quotient bit per cycle and a remainder check; a prime near
// 2^16 tries 254 divisors. Zero, one, two and three finish without a division.
// Reset clears the controller and output valid; a stalled output holds its beat.
`default_nettype none

module trial_division_prime_test_core import tdpt_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [8*((VALUE_WIDTH+7)/8)-1:0]    s_tdata,  // candidate
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [8*((VALUE_WIDTH+7)/8)-1:0]         m_tdata,  // tested_value
	output logic                                     m_tuser   // is_prime
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned DW = 8 * ((VALUE_WIDTH + 7) / 8);

	tdpt_cmd_t    cmd;
	tdpt_sts_t    sts;
	logic [W-1:0] out_value;

	tdpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdpt_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (s_tdata[W-1:0]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (out_value),
		.out_prime (m_tuser)
	);

	// Pad the result to whole bytes
	assign m_tdata = DW'(out_value);

`ifndef ASSERT_OFF
	// An accepted beat makes the core busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while candidate in work");

	// A result loaded into the output register shows up as valid
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

	// Zero and one are never flagged prime
	a_no_small_prime: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[W-1:1] != '0))
		else $error("zero or one flagged prime");

	// Load, divisor advance, divider start and divider step are never issued together
	a_div_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.div_start, cmd.div_step, cmd.inc_d, cmd.load}))
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire
